FILE: design/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the tick-driven i2c master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int UNIT_W         = 16;
    localparam int IN_TDATA_W     = 16;
    localparam int IN_TUSER_W     = 1;
    localparam int OUT_TDATA_W    = 16;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // one tick of the bus timebase, msb first
    typedef struct packed {
        logic       kind;
        logic       sda_level;
        logic       scl_level;
        logic [7:0] write_byte;
        cmd_t       command;
    } tick_item_t;

    // line drives and status after one tick, msb first
    typedef struct packed {
        logic       start_ok;
        logic       ack_seen;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_pull_low;
    } tick_result_t;

    localparam int IN_ITEM_W  = $bits(tick_item_t);
    localparam int OUT_ITEM_W = $bits(tick_result_t);

endpackage

FILE: design/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain i2c master stepped by bus timebase ticks: start, stop, write byte
// and read byte with nack, delays counted in units of unit_ticks ticks.
// ----------------------------------------------------------------------------
// Each stream transaction on the input is one tick and yields exactly one
// result transaction. The engine takes one tick per clock cycle unless the
// sink stalls, which holds off new ticks. A tick lands in an input register,
// the sequencer computes the new line drives and status in a single pass and
// the result register holds them until the sink takes them. A command is only
// picked up on a tick seen while the engine is idle; unit_ticks may be
// rewritten only while idle, and a value of zero counts as one.
module i2c_master_byte_engine #(
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // command[1:0], write_byte[9:2], scl_level[10], sda_level[11], zero fill
    input  logic [i2cm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // kind[0]
    input  logic [i2cm_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // scl_pull_low[0], sda_pull_low[1], busy_res[2], done_res[3],
    // read_byte[11:4], ack_seen[12], start_ok[13], zero fill
    output logic [i2cm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cm_pkg::UNIT_W-1:0]        cfg_data
);
    import i2cm_pkg::*;

    logic                in_valid_reg;
    tick_item_t          in_item_reg;
    logic                out_valid_reg;
    tick_result_t        out_item_reg;
    logic [UNIT_W-1:0]   unit_ticks_reg;
    tick_result_t        result;
    logic                out_free;
    logic                step;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            unit_ticks_reg <= UNIT_W'(1);
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                unit_ticks_reg <= cfg_data;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= tick_item_t'({s_axis_tuser[0], s_axis_tdata[IN_ITEM_W-2:0]});
        if (step)
            out_item_reg <= result;
    end

    i2cm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (in_item_reg),
        .unit_ticks (unit_ticks_reg),
        .result     (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_ITEM_W){1'b0}}, out_item_reg};

endmodule

FILE: design/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bit-level sequencer: updates the bus state by one tick per step and
// presents the result of that tick.
// ----------------------------------------------------------------------------
module i2cm_core #(
    parameter int TIMER_BITS = i2cm_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  i2cm_pkg::tick_item_t          item,
    input  logic [i2cm_pkg::UNIT_W-1:0]   unit_ticks,
    output i2cm_pkg::tick_result_t        result
);
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        P_IDLE, P_S_SAMPLE, P_S_SDA, P_S_SCL, P_P_SCL, P_P_SDA,
        P_W_RISE, P_W_STRETCH, P_W_FALL, P_W_ACKRISE, P_W_ACKSAMPLE,
        P_R_STRETCH, P_R_SAMPLE, P_R_FALL, P_R_NEXT, P_R_NACKRISE,
        P_R_NACKFALL, P_R_END, P_R_DONE
    } phase_t;

    localparam int CMP_W = (TIMER_BITS > UNIT_W) ? TIMER_BITS : UNIT_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             bit_index_reg, bit_index_next;
    logic [7:0]             shift_reg, shift_next;
    logic [TIMER_BITS-1:0]  timer_reg, timer_next;
    logic [1:0]             units_reg, units_next;
    logic                   scl_drive_reg, scl_drive_next;
    logic                   sda_drive_reg, sda_drive_next;
    logic                   ack_reg, ack_next;
    logic                   start_reg, start_next;
    logic [7:0]             last_read_reg, last_read_next;
    logic                   done_now;
    logic                   act;
    logic [TIMER_BITS-1:0]  unit_load;
    logic [CMP_W-1:0]       unit_ext;
    logic [3:0]             bit_inc;

    // zero counts as one, values beyond the timer saturate
    always_comb
    begin
        unit_ext = CMP_W'(unit_ticks);
        if (unit_ticks == '0)
            unit_load = TIMER_BITS'(1);
        else if (unit_ext > CMP_W'(TIMER_MAX))
            unit_load = TIMER_MAX;
        else
            unit_load = TIMER_BITS'(unit_ext);
    end

    assign bit_inc = bit_index_reg + 4'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_index_next = bit_index_reg;
        shift_next     = shift_reg;
        timer_next     = timer_reg;
        units_next     = units_reg;
        scl_drive_next = scl_drive_reg;
        sda_drive_next = sda_drive_reg;
        ack_next       = ack_reg;
        start_next     = start_reg;
        last_read_next = last_read_reg;
        done_now       = 1'b0;
        act            = 1'b0;

        if (phase_reg == P_IDLE)
        begin
            if (item.kind)
            begin
                case (item.command)
                    CMD_START:
                    begin
                        scl_drive_next = 1'b0;
                        sda_drive_next = 1'b0;
                        units_next     = 2'd0;
                        phase_next     = P_S_SAMPLE;
                    end
                    CMD_STOP:
                    begin
                        sda_drive_next = 1'b1;
                        scl_drive_next = 1'b1;
                        units_next     = 2'd2;
                        timer_next     = unit_load;
                        phase_next     = P_P_SCL;
                    end
                    CMD_WRITE:
                    begin
                        shift_next     = item.write_byte;
                        bit_index_next = 4'd0;
                        sda_drive_next = ~item.write_byte[7];
                        units_next     = 2'd2;
                        timer_next     = unit_load;
                        phase_next     = P_W_RISE;
                    end
                    default:
                    begin
                        shift_next     = 8'd0;
                        bit_index_next = 4'd0;
                        sda_drive_next = 1'b0;
                        scl_drive_next = 1'b0;
                        units_next     = 2'd0;
                        phase_next     = P_R_STRETCH;
                    end
                endcase
            end
        end
        else if (units_reg != 2'd0)
        begin
            timer_next = timer_reg - TIMER_BITS'(1);
            if (timer_next == '0)
            begin
                units_next = units_reg - 2'd1;
                if (units_next != 2'd0)
                    timer_next = unit_load;
                else
                    act = 1'b1;
            end
        end
        else
        begin
            act = 1'b1;
        end

        if (act)
        begin
            case (phase_reg)
                P_S_SAMPLE:
                begin
                    if (!item.sda_level || !item.scl_level)
                    begin
                        start_next = 1'b0;
                        phase_next = P_IDLE;
                        units_next = 2'd0;
                        timer_next = '0;
                        done_now   = 1'b1;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        units_next = 2'd1;
                        timer_next = unit_load;
                        phase_next = P_S_SDA;
                    end
                end
                P_S_SDA:
                begin
                    sda_drive_next = 1'b1;
                    units_next     = 2'd1;
                    timer_next     = unit_load;
                    phase_next     = P_S_SCL;
                end
                P_P_SCL:
                begin
                    scl_drive_next = 1'b0;
                    units_next     = 2'd1;
                    timer_next     = unit_load;
                    phase_next     = P_P_SDA;
                end
                P_W_RISE:
                begin
                    scl_drive_next = 1'b0;
                    units_next     = 2'd1;
                    timer_next     = unit_load;
                    phase_next     = P_W_STRETCH;
                end
                P_W_STRETCH:
                begin
                    // hold while the slave stretches the clock
                    if (item.scl_level)
                    begin
                        units_next = 2'd1;
                        timer_next = unit_load;
                        phase_next = P_W_FALL;
                    end
                end
                P_W_FALL:
                begin
                    scl_drive_next = 1'b1;
                    shift_next     = {shift_reg[6:0], 1'b0};
                    bit_index_next = bit_inc;
                    timer_next     = unit_load;
                    if (bit_inc >= 4'd8)
                    begin
                        sda_drive_next = 1'b0;
                        units_next     = 2'd1;
                        phase_next     = P_W_ACKRISE;
                    end
                    else
                    begin
                        sda_drive_next = ~shift_reg[6];
                        units_next     = 2'd2;
                        phase_next     = P_W_RISE;
                    end
                end
                P_W_ACKRISE:
                begin
                    scl_drive_next = 1'b0;
                    units_next     = 2'd2;
                    timer_next     = unit_load;
                    phase_next     = P_W_ACKSAMPLE;
                end
                P_R_STRETCH:
                begin
                    if (item.scl_level)
                    begin
                        units_next = 2'd1;
                        timer_next = unit_load;
                        phase_next = P_R_SAMPLE;
                    end
                end
                P_R_SAMPLE:
                begin
                    shift_next = {shift_reg[6:0], item.sda_level};
                    units_next = 2'd2;
                    timer_next = unit_load;
                    phase_next = P_R_FALL;
                end
                P_R_FALL:
                begin
                    scl_drive_next = 1'b1;
                    bit_index_next = bit_inc;
                    units_next     = 2'd2;
                    timer_next     = unit_load;
                    phase_next     = P_R_NEXT;
                end
                P_R_NEXT:
                begin
                    if (bit_index_reg < 4'd8)
                    begin
                        scl_drive_next = 1'b0;
                        units_next     = 2'd0;
                        phase_next     = P_R_STRETCH;
                    end
                    else
                    begin
                        sda_drive_next = 1'b0;
                        units_next     = 2'd1;
                        timer_next     = unit_load;
                        phase_next     = P_R_NACKRISE;
                    end
                end
                P_R_NACKRISE:
                begin
                    scl_drive_next = 1'b0;
                    units_next     = 2'd2;
                    timer_next     = unit_load;
                    phase_next     = P_R_NACKFALL;
                end
                P_R_NACKFALL:
                begin
                    scl_drive_next = 1'b1;
                    units_next     = 2'd1;
                    timer_next     = unit_load;
                    phase_next     = P_R_END;
                end
                P_R_END:
                begin
                    sda_drive_next = 1'b0;
                    units_next     = 2'd1;
                    timer_next     = unit_load;
                    phase_next     = P_R_DONE;
                end
                default:
                begin
                    // last action of a command, plus recovery from unused codes
                    if (phase_reg == P_S_SCL)
                        scl_drive_next = 1'b1;
                    if (phase_reg == P_P_SDA)
                        sda_drive_next = 1'b0;
                    if (phase_reg == P_W_ACKSAMPLE)
                    begin
                        ack_next       = ~item.sda_level;
                        scl_drive_next = 1'b1;
                    end
                    if (phase_reg == P_R_DONE)
                        last_read_next = shift_reg;
                    phase_next = P_IDLE;
                    units_next = 2'd0;
                    timer_next = '0;
                    done_now   = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= P_IDLE;
            bit_index_reg <= 4'd0;
            shift_reg     <= 8'd0;
            timer_reg     <= '0;
            units_reg     <= 2'd0;
            scl_drive_reg <= 1'b0;
            sda_drive_reg <= 1'b0;
            ack_reg       <= 1'b0;
            start_reg     <= 1'b0;
            last_read_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            bit_index_reg <= bit_index_next;
            shift_reg     <= shift_next;
            timer_reg     <= timer_next;
            units_reg     <= units_next;
            scl_drive_reg <= scl_drive_next;
            sda_drive_reg <= sda_drive_next;
            ack_reg       <= ack_next;
            start_reg     <= start_next;
            last_read_reg <= last_read_next;
        end
    end

    always_comb
    begin
        result.scl_pull_low = scl_drive_next;
        result.sda_pull_low = sda_drive_next;
        result.busy_res     = (phase_next != P_IDLE);
        result.done_res     = done_now;
        result.read_byte    = last_read_next;
        result.ack_seen     = ack_next;
        result.start_ok     = start_next;
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tick-driven i2c master byte engine. A bus model
// answers each tick with line levels derived from the expected master drives
// (slave data, ack and clock stretching included). Every result transaction
// is compared against an in-bench model of the sequencer or a typed result.
// ----------------------------------------------------------------------------
module tb;
    import i2cm_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START_CHECK,
        ST_START_SDA,
        ST_START_SCL,
        ST_STOP_SCL,
        ST_STOP_SDA,
        ST_WR_RISE,
        ST_WR_STRETCH,
        ST_WR_FALL,
        ST_WR_ACK_RISE,
        ST_WR_ACK_SAMPLE,
        ST_RD_STRETCH,
        ST_RD_SAMPLE,
        ST_RD_FALL,
        ST_RD_NEXT,
        ST_RD_NACK_RISE,
        ST_RD_NACK_FALL,
        ST_RD_END,
        ST_RD_DONE
    } bus_phase_t;

    // follow rows issue a command and let the bus model run it to the end,
    // the others are single ticks with the result typed in
    typedef struct packed {
        logic         kind;
        cmd_t         cmd;
        logic [7:0]   data;
        logic         scl;
        logic         sda;
        logic         follow;
        tick_result_t want;
        logic [2:0]   stretch;
        logic         ack;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [UNIT_W-1:0]      cfg_data = '0;

    // sequencer model state
    bus_phase_t        bus_phase = ST_IDLE;
    logic [3:0]        bit_cnt = '0;
    logic [7:0]        shreg = '0;
    logic [15:0]       unit_cnt = '0;
    logic [1:0]        units_pend = '0;
    logic              drv_scl = 1'b0;
    logic              drv_sda = 1'b0;
    logic              ack_q = 1'b0;
    logic              start_q = 1'b0;
    logic              tick_done = 1'b0;
    logic [7:0]        rx_byte = '0;
    logic [UNIT_W-1:0] unit_len = 16'd1;

    // slave side of the bus model
    logic [7:0] slave_byte = '0;
    logic       slave_ack = 1'b0;
    int         stretch_max = 0;
    int         stretch_run = 0;
    int         noise_pct = 0;

    tick_result_t status_q[$];
    dir_row_t     dir_rows[$];
    int           ticks_sent = 0;
    int           results_seen = 0;
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           backlog_done = 1'b0;

    i2c_master_byte_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [15:0] unit_reload();
        return (unit_len == '0) ? 16'd1 : unit_len;
    endfunction

    function automatic tick_result_t mk_res(input logic sok, input logic ack,
                                            input logic [7:0] rbyte, input logic done,
                                            input logic busy, input logic sda,
                                            input logic scl);
        return {sok, ack, rbyte, done, busy, sda, scl};
    endfunction

    task automatic arm_delay(input logic [1:0] n, input bus_phase_t nxt);
        units_pend = n;
        unit_cnt   = unit_reload();
        bus_phase  = nxt;
    endtask

    task automatic end_command();
        bus_phase  = ST_IDLE;
        units_pend = '0;
        unit_cnt   = '0;
        tick_done  = 1'b1;
    endtask

    task automatic put_bit();
        drv_sda = ~shreg[7];
        arm_delay(2'd2, ST_WR_RISE);
    endtask

    task automatic rd_rise();
        drv_scl    = 1'b0;
        units_pend = '0;
        bus_phase  = ST_RD_STRETCH;
    endtask

    task automatic seq_action(input logic scl, input logic sda);
        case (bus_phase)
            ST_START_CHECK:
            begin
                if (!sda || !scl)
                begin
                    start_q = 1'b0;
                    end_command();
                end
                else
                begin
                    start_q = 1'b1;
                    arm_delay(2'd1, ST_START_SDA);
                end
            end
            ST_START_SDA:
            begin
                drv_sda = 1'b1;
                arm_delay(2'd1, ST_START_SCL);
            end
            ST_START_SCL:
            begin
                drv_scl = 1'b1;
                end_command();
            end
            ST_STOP_SCL:
            begin
                drv_scl = 1'b0;
                arm_delay(2'd1, ST_STOP_SDA);
            end
            ST_STOP_SDA:
            begin
                drv_sda = 1'b0;
                end_command();
            end
            ST_WR_RISE:
            begin
                drv_scl = 1'b0;
                arm_delay(2'd1, ST_WR_STRETCH);
            end
            ST_WR_STRETCH:
            begin
                if (scl)
                    arm_delay(2'd1, ST_WR_FALL);
            end
            ST_WR_FALL:
            begin
                drv_scl = 1'b1;
                shreg   = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8)
                begin
                    drv_sda = 1'b0;
                    arm_delay(2'd1, ST_WR_ACK_RISE);
                end
                else
                    put_bit();
            end
            ST_WR_ACK_RISE:
            begin
                drv_scl = 1'b0;
                arm_delay(2'd2, ST_WR_ACK_SAMPLE);
            end
            ST_WR_ACK_SAMPLE:
            begin
                ack_q   = !sda;
                drv_scl = 1'b1;
                end_command();
            end
            ST_RD_STRETCH:
            begin
                if (scl)
                    arm_delay(2'd1, ST_RD_SAMPLE);
            end
            ST_RD_SAMPLE:
            begin
                shreg = {shreg[6:0], sda};
                arm_delay(2'd2, ST_RD_FALL);
            end
            ST_RD_FALL:
            begin
                drv_scl = 1'b1;
                bit_cnt = bit_cnt + 4'd1;
                arm_delay(2'd2, ST_RD_NEXT);
            end
            ST_RD_NEXT:
            begin
                if (bit_cnt < 4'd8)
                    rd_rise();
                else
                begin
                    drv_sda = 1'b0;
                    arm_delay(2'd1, ST_RD_NACK_RISE);
                end
            end
            ST_RD_NACK_RISE:
            begin
                drv_scl = 1'b0;
                arm_delay(2'd2, ST_RD_NACK_FALL);
            end
            ST_RD_NACK_FALL:
            begin
                drv_scl = 1'b1;
                arm_delay(2'd1, ST_RD_END);
            end
            ST_RD_END:
            begin
                drv_sda = 1'b0;
                arm_delay(2'd1, ST_RD_DONE);
            end
            ST_RD_DONE:
            begin
                rx_byte = shreg;
                end_command();
            end
            default:
                end_command();
        endcase
    endtask

    // one tick through the sequencer model, returns the line drives and status
    task automatic seq_tick(input tick_item_t it, output tick_result_t r);
        tick_done = 1'b0;
        if (bus_phase == ST_IDLE)
        begin
            if (it.kind)
            begin
                case (it.command)
                    CMD_START:
                    begin
                        drv_scl    = 1'b0;
                        drv_sda    = 1'b0;
                        units_pend = '0;
                        bus_phase  = ST_START_CHECK;
                    end
                    CMD_STOP:
                    begin
                        drv_sda = 1'b1;
                        drv_scl = 1'b1;
                        arm_delay(2'd2, ST_STOP_SCL);
                    end
                    CMD_WRITE:
                    begin
                        shreg   = it.write_byte;
                        bit_cnt = '0;
                        put_bit();
                    end
                    default:
                    begin
                        shreg   = '0;
                        bit_cnt = '0;
                        drv_sda = 1'b0;
                        rd_rise();
                    end
                endcase
            end
        end
        else if (units_pend != '0)
        begin
            unit_cnt = unit_cnt - 16'd1;
            if (unit_cnt == '0)
            begin
                units_pend = units_pend - 2'd1;
                if (units_pend != '0)
                    unit_cnt = unit_reload();
                else
                    seq_action(it.scl_level, it.sda_level);
            end
        end
        else
            seq_action(it.scl_level, it.sda_level);
        r = {start_q, ack_q, rx_byte, tick_done, bus_phase != ST_IDLE, drv_sda, drv_scl};
    endtask

    task automatic send_tick(input tick_item_t it, input logic use_typed,
                             input tick_result_t typed);
        tick_result_t want;
        if (!(ticks_sent >= 800 && ticks_sent < 1100) && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, it.sda_level, it.scl_level, it.write_byte, it.command};
        s_axis_tuser  <= it.kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        seq_tick(it, want);
        status_q.push_back(use_typed ? typed : want);
        ticks_sent++;
    endtask

    // levels seen on the wires: released lines read high unless the slave
    // pulls them, scl held low while the slave stretches, noise flips one at random
    task automatic bus_tick(input logic kind, input cmd_t cmd, input logic [7:0] wbyte);
        tick_item_t it;
        logic       hold;
        logic       slave_sda;
        hold = 1'b0;
        if (bus_phase == ST_WR_STRETCH || bus_phase == ST_RD_STRETCH)
        begin
            hold = (stretch_run < stretch_max);
            if (hold)
                stretch_run++;
        end
        else
            stretch_run = 0;
        slave_sda = 1'b1;
        if (bus_phase == ST_RD_SAMPLE)
            slave_sda = slave_byte[3'd7 - bit_cnt[2:0]];
        else if (bus_phase == ST_WR_ACK_RISE || bus_phase == ST_WR_ACK_SAMPLE)
            slave_sda = !slave_ack;
        it.kind       = kind;
        it.command    = cmd;
        it.write_byte = wbyte;
        it.scl_level  = !drv_scl && !hold;
        it.sda_level  = !drv_sda && slave_sda;
        if ($urandom_range(99) < noise_pct)
        begin
            if ($urandom_range(1) == 1)
                it.scl_level = !it.scl_level;
            else
                it.sda_level = !it.sda_level;
        end
        send_tick(it, 1'b0, '0);
    endtask

    task automatic write_unit(input logic [UNIT_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        // let the two pipeline stages settle
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        unit_len = v;
    endtask

    task automatic run_random(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items || bus_phase != ST_IDLE)
        begin
            if (bus_phase == ST_IDLE && $urandom_range(99) < 40)
            begin
                slave_byte  = 8'($urandom);
                slave_ack   = ($urandom_range(99) < 70);
                stretch_max = $urandom_range(0, 5);
                bus_tick(1'b1, cmd_t'(2'($urandom_range(3))), 8'($urandom));
            end
            else
                // filler ticks; a stray command is ignored while busy, taken when idle
                bus_tick($urandom_range(99) < 4, cmd_t'(2'($urandom_range(3))),
                         8'($urandom));
            sent++;
        end
    endtask

    task automatic fixed_row(input logic kind, input cmd_t cmd, input logic [7:0] data,
                             input logic scl, input logic sda, input tick_result_t want);
        dir_row_t row;
        row        = '0;
        row.kind   = kind;
        row.cmd    = cmd;
        row.data   = data;
        row.scl    = scl;
        row.sda    = sda;
        row.want   = want;
        dir_rows.push_back(row);
    endtask

    task automatic cmd_row(input logic kind, input cmd_t cmd, input logic [7:0] data,
                           input logic [2:0] stretch, input logic ack);
        dir_row_t row;
        row         = '0;
        row.kind    = kind;
        row.cmd     = cmd;
        row.data    = data;
        row.follow  = 1'b1;
        row.stretch = stretch;
        row.ack     = ack;
        dir_rows.push_back(row);
    endtask

    // result checker
    always @(posedge clk)
    begin
        tick_result_t got;
        tick_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[OUT_ITEM_W-1:0];
            results_seen++;
            if (status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transaction %h", m_axis_tdata);
            end
            else
            begin
                want = status_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("result %0d (want/got): scl %b/%b sda %b/%b busy %b/%b",
                               results_seen,
                               want.scl_pull_low, got.scl_pull_low,
                               want.sda_pull_low, got.sda_pull_low,
                               want.busy_res, got.busy_res);
                        $display(" done %b/%b read %h/%h ack %b/%b start %b/%b",
                                 want.done_res, got.done_res,
                                 want.read_byte, got.read_byte,
                                 want.ack_seen, got.ack_seen,
                                 want.start_ok, got.start_ok);
                    end
                end
            end
        end
    end

    // result sink with random stalls, one long hold-off and a window with no stalls
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!backlog_done && results_seen >= 400)
            begin
                backlog_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (80) @(posedge clk);
            end
            m_axis_tready <= (results_seen >= 1300 && results_seen < 1600) ||
                             ($urandom_range(99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        dir_row_t   row;
        tick_item_t it;

        fixed_row(1'b0, CMD_START, 8'h00, 1'b1, 1'b1, '0);
        // kind clear: command fields are don't-care
        fixed_row(1'b0, CMD_READ, 8'hFF, 1'b0, 1'b0, '0);
        fixed_row(1'b1, CMD_START, 8'h00, 1'b1, 1'b1,
                  mk_res(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        // start with scl low
        fixed_row(1'b0, CMD_START, 8'h00, 1'b0, 1'b1,
                  mk_res(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        fixed_row(1'b1, CMD_START, 8'h00, 1'b1, 1'b1,
                  mk_res(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        // start with sda low
        fixed_row(1'b0, CMD_START, 8'h00, 1'b1, 1'b0,
                  mk_res(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
        fixed_row(1'b1, CMD_START, 8'h00, 1'b1, 1'b1,
                  mk_res(1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        // new command while busy is dropped, the start check passes
        fixed_row(1'b1, CMD_WRITE, 8'h00, 1'b1, 1'b1,
                  mk_res(1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
        cmd_row(1'b0, CMD_START, 8'h00, 3'd0, 1'b0);
        cmd_row(1'b1, CMD_WRITE, 8'hA5, 3'd0, 1'b1);
        cmd_row(1'b1, CMD_WRITE, 8'hFF, 3'd3, 1'b0);
        cmd_row(1'b1, CMD_WRITE, 8'h00, 3'd2, 1'b1);
        cmd_row(1'b1, CMD_READ, 8'h00, 3'd0, 1'b0);
        cmd_row(1'b1, CMD_READ, 8'hFF, 3'd3, 1'b0);
        cmd_row(1'b1, CMD_READ, 8'h5A, 3'd1, 1'b0);
        cmd_row(1'b1, CMD_STOP, 8'h00, 3'd0, 1'b0);
        cmd_row(1'b1, CMD_STOP, 8'hFF, 3'd0, 1'b0);
        cmd_row(1'b1, CMD_START, 8'h00, 3'd0, 1'b0);
        cmd_row(1'b1, CMD_READ, 8'hC3, 3'd0, 1'b0);
        cmd_row(1'b1, CMD_STOP, 8'h00, 3'd0, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.follow)
            begin
                slave_byte  = row.data;
                slave_ack   = row.ack;
                stretch_max = row.stretch;
                bus_tick(row.kind, row.cmd, row.data);
                while (bus_phase != ST_IDLE)
                    bus_tick(1'b0, CMD_START, 8'h00);
            end
            else
            begin
                it = {row.kind, row.sda, row.scl, row.data, row.cmd};
                send_tick(it, 1'b1, row.want);
            end
        end

        noise_pct = 3;
        write_unit(16'd0);
        run_random(200);
        write_unit(16'd2);
        run_random(200);
        write_unit(16'd3);
        run_random(200);
        write_unit(16'($urandom_range(4, 9)));
        run_random(200);
        write_unit(16'd1);
        run_random(200);

        // longest unit: a failing start, then a passing start held in its delay
        write_unit(16'hFFFF);
        noise_pct   = 0;
        stretch_max = 0;
        bus_tick(1'b1, CMD_START, 8'h00);
        it = {1'b0, 1'b1, 1'b0, 8'h00, CMD_START};
        send_tick(it, 1'b0, '0);
        bus_tick(1'b1, CMD_START, 8'h00);
        repeat (20)
            bus_tick(1'b0, CMD_START, 8'h00);

        s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/i2cm_pkg.sv
design/i2cm_core.sv
design/i2c_master_byte_engine.sv
test/tb.sv
